/* rtl/mma_pkg.sv */
// mma_pkg: operation codes, fixed widths and the structs shared by the
// matrix multiply-accumulate top level and its cells. No dependencies.
package mma_pkg;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned IDX_W   = 8;   // index field width, enough for 256
  localparam int unsigned N_W     = 9;   // active size, up to 256
  localparam int unsigned DIM_W   = 6;

  localparam logic [OP_W-1:0] OP_WR_A = 3'd0;
  localparam logic [OP_W-1:0] OP_WR_B = 3'd1;
  localparam logic [OP_W-1:0] OP_WR_C = 3'd2;
  localparam logic [OP_W-1:0] OP_MAC  = 3'd3;
  localparam logic [OP_W-1:0] OP_RD_C = 3'd4;

  // element of A travelling along the chain
  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] a;
    logic [IDX_W-1:0]  i;
    logic [IDX_W-1:0]  k;
    logic              first;
    logic              last;
  } token_t;

  // host access to the column stores held in the cells
  typedef struct packed {
    logic              wr_b;
    logic              wr_c;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [WORD_W-1:0] data;
  } host_t;

endpackage

/* rtl/mma_cell.sv */
// mma_cell: one column of the multiply-accumulate chain, holding column j
// of B and of C. Depends on mma_pkg.
module mma_cell import mma_pkg::*; #(
  parameter int unsigned DIM = 32,
  parameter int unsigned J   = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [N_W-1:0]    n,
  input  host_t             host,
  input  token_t            tin,
  output token_t            tout,
  output logic [WORD_W-1:0] rd_data
);

  localparam int unsigned IW    = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int unsigned DEPTH = 1 << IW;

  logic [WORD_W-1:0] b_mem [0:DEPTH-1];
  logic [WORD_W-1:0] c_mem [0:DEPTH-1];

  token_t            s1;
  logic [WORD_W-1:0] b_rd;
  logic              s2_valid, s2_first, s2_last;
  logic [IW-1:0]     s2_i;
  logic [WORD_W-1:0] prod;
  logic [WORD_W-1:0] acc;
  logic [WORD_W-1:0] acc_next;
  logic              s3_wr;
  logic [IW-1:0]     s3_i;
  logic [WORD_W-1:0] s3_sum;
  logic [WORD_W-1:0] c_rd;
  logic [IW-1:0]     c_addr;
  logic              mine;
  logic              col_active;

  assign mine       = (host.col == IDX_W'(J));
  assign col_active = (N_W'(J) < n);
  assign acc_next   = (s2_first ? '0 : acc) + prod;
  assign c_addr     = (s2_valid && s2_last) ? s2_i : host.row[IW-1:0];
  assign tout       = s1;
  assign rd_data    = c_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_wr    <= 1'b0;
    end else begin
      s1.valid <= tin.valid;
      s2_valid <= s1.valid;
      s3_wr    <= s2_valid && s2_last && col_active;
    end
    s1.a     <= tin.a;
    s1.i     <= tin.i;
    s1.k     <= tin.k;
    s1.first <= tin.first;
    s1.last  <= tin.last;
    b_rd     <= b_mem[tin.k[IW-1:0]];
    prod     <= s1.a * b_rd;
    s2_i     <= s1.i[IW-1:0];
    s2_first <= s1.first;
    s2_last  <= s1.last;
    if (s2_valid) begin
      acc <= acc_next;
    end
    s3_sum   <= acc_next;
    s3_i     <= s2_i;
    c_rd     <= c_mem[c_addr];
    if (host.wr_b && mine) begin
      b_mem[host.row[IW-1:0]] <= host.data;
    end
    // accumulated row sum lands in C, host loads only happen while idle
    if (host.wr_c && mine) begin
      c_mem[host.row[IW-1:0]] <= host.data;
    end else if (s3_wr) begin
      c_mem[s3_i] <= c_rd + s3_sum;
    end
  end

endmodule

/* rtl/matrix_multiply_accumulate.sv */
// matrix_multiply_accumulate: C = C + A*B over the active square part.
// Holds A and the feed sequencer; B and C live in a chain of mma_cell.
// Depends on mma_pkg and mma_cell.
//
//  channel  signals                             direction
//  in       in_valid/in_ready, operation, row,   into block
//           column, value
//  out      out_valid/out_ready, read_value      out of block
//  cfg      cfg_valid/cfg_ready, dim_in_use      into block
//
// loads, unknown codes and a size-zero multiply answer in the cycle after
// they are taken, a read of C after passing through the read state. during
// a multiply one element of A enters the cell chain per cycle, then the
// chain and cell pipeline drain. one item is in progress at a time; the next
// is taken once the result slot is free or being emptied. synchronous reset
// sets the active size register dim to 32.
module matrix_multiply_accumulate import mma_pkg::*; #(
  parameter int unsigned MATRIX_DIM = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [OP_W-1:0]          operation,
  input  logic [4:0]               row,
  input  logic [4:0]               column,
  input  logic signed [WORD_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [WORD_W-1:0] read_value,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [DIM_W-1:0]         dim_in_use
);

  localparam int unsigned IW        = (MATRIX_DIM > 1) ? $clog2(MATRIX_DIM) : 1;
  localparam int unsigned A_DEPTH   = 1 << (2 * IW);
  localparam int unsigned DRAIN_LEN = MATRIX_DIM + 6;
  localparam int unsigned CW        = $clog2(DRAIN_LEN + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_FEED  = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  logic [1:0]        state;
  logic [DIM_W-1:0]  dim;
  logic [N_W-1:0]    n;
  logic              in_acc;
  logic              in_range;
  logic [IDX_W-1:0]  row_x, col_x;
  logic [IW-1:0]     cnt_i, cnt_k;
  logic [CW-1:0]     drain_cnt;
  logic              read_inside;
  logic [IW-1:0]     read_col;
  logic              feed_valid, feed_first, feed_last;
  logic [IW-1:0]     feed_i, feed_k;
  logic [WORD_W-1:0] a_rd;
  logic [WORD_W-1:0] a_mem [0:A_DEPTH-1];
  logic              k_end, i_end;
  host_t             host;
  token_t            tok [0:MATRIX_DIM-1];
  logic [WORD_W-1:0] cell_rd [0:MATRIX_DIM-1];

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE) && (!out_valid || out_ready);
  assign in_acc    = in_valid && in_ready;
  assign row_x     = IDX_W'(row);
  assign col_x     = IDX_W'(column);
  assign in_range  = ({1'b0, row_x} < N_W'(MATRIX_DIM)) &&
                     ({1'b0, col_x} < N_W'(MATRIX_DIM));
  assign n         = (N_W'(dim) > N_W'(MATRIX_DIM)) ? N_W'(MATRIX_DIM) : N_W'(dim);
  assign k_end     = (N_W'(cnt_k) == n - 1'b1);
  assign i_end     = (N_W'(cnt_i) == n - 1'b1);

  assign host.wr_b = in_acc && (operation == OP_WR_B) && in_range;
  assign host.wr_c = in_acc && (operation == OP_WR_C) && in_range;
  assign host.row  = row_x;
  assign host.col  = col_x;
  assign host.data = value;

  assign tok[0].valid = feed_valid;
  assign tok[0].a     = a_rd;
  assign tok[0].i     = IDX_W'(feed_i);
  assign tok[0].k     = IDX_W'(feed_k);
  assign tok[0].first = feed_first;
  assign tok[0].last  = feed_last;

  genvar j;
  generate
    for (j = 0; j < MATRIX_DIM; j++) begin : g_cell
      if (j == MATRIX_DIM - 1) begin : g_end
        mma_cell #(.DIM(MATRIX_DIM), .J(j)) u_cell (
          .clk(clk), .rst(rst), .n(n), .host(host),
          .tin(tok[j]), .tout(), .rd_data(cell_rd[j])
        );
      end else begin : g_mid
        mma_cell #(.DIM(MATRIX_DIM), .J(j)) u_cell (
          .clk(clk), .rst(rst), .n(n), .host(host),
          .tin(tok[j]), .tout(tok[j+1]), .rd_data(cell_rd[j])
        );
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (in_acc && (operation == OP_WR_A) && in_range) begin
      a_mem[{row_x[IW-1:0], col_x[IW-1:0]}] <= value;
    end
    a_rd <= a_mem[{cnt_i, cnt_k}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      dim        <= DIM_W'(32);
      out_valid  <= 1'b0;
      feed_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        dim <= dim_in_use;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      feed_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            case (operation)
              OP_MAC: begin
                cnt_i <= '0;
                cnt_k <= '0;
                if (n == '0) begin
                  out_valid  <= 1'b1;
                  read_value <= '0;
                end else begin
                  state <= ST_FEED;
                end
              end
              OP_RD_C: begin
                state       <= ST_READ;
                read_inside <= in_range;
                read_col    <= col_x[IW-1:0];
              end
              default: begin
                out_valid  <= 1'b1;
                read_value <= '0;
              end
            endcase
          end
        end
        ST_READ: begin
          out_valid  <= 1'b1;
          read_value <= read_inside ? cell_rd[read_col] : '0;
          state      <= ST_IDLE;
        end
        ST_FEED: begin
          feed_valid <= 1'b1;
          feed_i     <= cnt_i;
          feed_k     <= cnt_k;
          feed_first <= (cnt_k == '0);
          feed_last  <= k_end;
          if (k_end) begin
            cnt_k <= '0;
            cnt_i <= cnt_i + 1'b1;
            if (i_end) begin
              state     <= ST_DRAIN;
              drain_cnt <= '0;
            end
          end else begin
            cnt_k <= cnt_k + 1'b1;
          end
        end
        ST_DRAIN: begin
          drain_cnt <= drain_cnt + 1'b1;
          if (drain_cnt == CW'(DRAIN_LEN - 1)) begin
            out_valid  <= 1'b1;
            read_value <= '0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // the result slot stays empty while an item is in progress
  a_slot_empty: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !out_valid)
    else $error("result present while busy");

  a_feed_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FEED) |-> ((N_W'(cnt_k) < n) && (N_W'(cnt_i) < n)))
    else $error("feed index beyond active size");

  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(in_valid && in_ready) || ($past(state) != ST_IDLE)))
    else $error("result without an item");
`endif

endmodule
